[rtl/core/lbps_pkg.sv]
`timescale 1ns / 1ps

package lbps_pkg;

    // table geometry
    localparam int PATTERNS = 16;
    localparam int SLOTS    = 4;

    localparam int PAT_AW = $clog2(PATTERNS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int THR_AW = $clog2(PATTERNS * SLOTS);

    // field widths
    localparam int ACT_W    = 2;
    localparam int STATUS_W = 4;
    localparam int THR_W    = 8;
    localparam int PC_W     = 3;
    localparam int COLOR_W  = 3;
    localparam int ATTR_W   = PC_W + COLOR_W + 1;

    // command codes
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SELECT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_THR    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ATTR   = 2'd3;

    // fixed statuses
    localparam logic [STATUS_W-1:0] ST_OFF = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ON  = 4'd1;

    localparam logic [COLOR_W-1:0] DRIVE_NONE = 3'd0;
    localparam logic [COLOR_W-1:0] DRIVE_ALL  = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [STATUS_W-1:0] status;
        logic [1:0]          slot;
        logic [THR_W-1:0]    threshold;
        logic [PC_W-1:0]     phase_count;
        logic [COLOR_W-1:0]  color;
        logic                repeat_req;
    } cmd_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  led_drive;
        logic [STATUS_W-1:0] current_status;
    } res_word_t;

    // threshold memory address of one pattern slot
    function automatic logic [THR_AW-1:0] thr_addr(
        input logic [STATUS_W-1:0] pat,
        input logic [SLOT_W-1:0]   ph
    );
        return THR_AW'(pat) * THR_AW'(SLOTS) + THR_AW'(ph);
    endfunction

endpackage

[rtl/core/lbps_ram.sv]
`timescale 1ns / 1ps

module lbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/led_blink_pattern_sequencer_top.sv]
`timescale 1ns / 1ps

// RGB LED blink-pattern player. Each command word is a tick (100 ms), a
// status select, a threshold write or a pattern attribute write; each gives
// one result word with the LED drive and the status in effect afterwards.
// Select, write and ticks in status off/on pass from acceptance through S_FIN
// to a registered result; a tick in a blinking status passes through S_ATTR,
// S_PHASE, S_LAST and S_FIN, set by three dependent reads of the pattern
// memories (attributes, phase threshold, last threshold), each read registered.
// A new command is taken while a result still waits on the output; a command
// finishes only once the output is free. Both pattern tables hold anything until written.
module led_blink_pattern_sequencer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  lbps_pkg::cmd_word_t  cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lbps_pkg::res_word_t  res
);

    import lbps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ATTR  = 3'd1;
    localparam logic [2:0] S_PHASE = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [PC_W-1:0] SLOTS_PC = PC_W'(SLOTS);

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] active_status_reg, active_status_next;
    logic [THR_W-1:0]    tick_count_reg, tick_count_next;
    logic [PC_W-1:0]     phase_index_reg, phase_index_next;
    logic [COLOR_W-1:0]  drive_bits_reg, drive_bits_next;
    logic [STATUS_W-1:0] pat_reg, pat_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                rep_reg, rep_next;
    logic                res_valid_reg, res_valid_next;
    res_word_t           res_reg, res_next;

    logic                cmd_fire;
    logic                thr_we, attr_we;
    logic [THR_AW-1:0]   thr_waddr, thr_raddr;
    logic [THR_W-1:0]    thr_wdata, thr_rdata;
    logic [PAT_AW-1:0]   attr_waddr, attr_raddr;
    logic [ATTR_W-1:0]   attr_wdata, attr_rdata;

    logic [PC_W-1:0]     attr_pc, pc_eff, phase_eff, phase_inc, pc_last;
    logic [COLOR_W-1:0]  attr_color;
    logic                attr_rep;

    // pattern memories
    lbps_ram #(
        .WIDTH (THR_W),
        .DEPTH (PATTERNS * SLOTS)
    ) u_thr_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (thr_waddr),
        .wdata (thr_wdata),
        .raddr (thr_raddr),
        .rdata (thr_rdata)
    );

    lbps_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (PATTERNS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (attr_waddr),
        .wdata (attr_wdata),
        .raddr (attr_raddr),
        .rdata (attr_rdata)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // attribute decode with phase count clamped to 1..SLOTS
    assign attr_pc    = attr_rdata[PC_W-1:0];
    assign attr_color = attr_rdata[PC_W +: COLOR_W];
    assign attr_rep   = attr_rdata[ATTR_W-1];
    assign pc_eff     = (attr_pc == '0) ? PC_W'(1) :
                        ((attr_pc > SLOTS_PC) ? SLOTS_PC : attr_pc);
    assign phase_eff  = (phase_index_reg >= pc_eff) ? '0 : phase_index_reg;
    assign phase_inc  = phase_index_reg + PC_W'(1);
    assign pc_last    = pc_reg - PC_W'(1);

    // command sequencer
    always_comb
    begin
        state_next         = state_reg;
        active_status_next = active_status_reg;
        tick_count_next    = tick_count_reg;
        phase_index_next   = phase_index_reg;
        drive_bits_next    = drive_bits_reg;
        pat_next           = pat_reg;
        pc_next            = pc_reg;
        color_next         = color_reg;
        rep_next           = rep_reg;
        res_next           = res_reg;
        res_valid_next     = res_valid_reg && res_stall;

        thr_we     = 1'b0;
        thr_waddr  = thr_addr(cmd.status, cmd.slot[SLOT_W-1:0]);
        thr_wdata  = cmd.threshold;
        attr_we    = 1'b0;
        attr_waddr = cmd.status[PAT_AW-1:0];
        attr_wdata = {cmd.repeat_req, cmd.color, cmd.phase_count};
        attr_raddr = active_status_reg[PAT_AW-1:0];
        thr_raddr  = thr_addr(pat_reg, phase_index_reg[SLOT_W-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    pat_next   = active_status_reg;
                    state_next = S_FIN;
                    unique case (cmd.action)
                        ACT_TICK:
                        begin
                            if (active_status_reg == ST_OFF)
                            begin
                                drive_bits_next = DRIVE_NONE;
                            end
                            else if (active_status_reg == ST_ON)
                            begin
                                drive_bits_next = DRIVE_ALL;
                            end
                            else if (active_status_reg < PATTERNS)
                            begin
                                state_next = S_ATTR;
                            end
                        end
                        ACT_SELECT:
                        begin
                            if (cmd.status < PATTERNS && cmd.status != active_status_reg)
                            begin
                                active_status_next = cmd.status;
                                tick_count_next    = '0;
                                phase_index_next   = '0;
                            end
                        end
                        ACT_THR:
                        begin
                            thr_we = (cmd.status < PATTERNS) && (cmd.slot < SLOTS);
                        end
                        ACT_ATTR:
                        begin
                            attr_we = (cmd.status < PATTERNS);
                        end
                    endcase
                end
            end
            // attributes in: clamp phase, fetch its threshold
            S_ATTR:
            begin
                pc_next          = pc_eff;
                color_next       = attr_color;
                rep_next         = attr_rep;
                phase_index_next = phase_eff;
                thr_raddr        = thr_addr(pat_reg, phase_eff[SLOT_W-1:0]);
                state_next       = S_PHASE;
            end
            // phase threshold in: drive or advance, fetch last threshold
            S_PHASE:
            begin
                if (tick_count_reg < thr_rdata)
                begin
                    drive_bits_next = phase_index_reg[0] ? DRIVE_NONE :
                                      (drive_bits_reg | color_reg);
                end
                else if (phase_inc >= pc_reg)
                begin
                    phase_index_next = '0;
                    if (!rep_reg)
                    begin
                        active_status_next = ST_OFF;
                    end
                end
                else
                begin
                    phase_index_next = phase_inc;
                end
                tick_count_next = tick_count_reg + THR_W'(1);
                thr_raddr       = thr_addr(pat_reg, pc_last[SLOT_W-1:0]);
                state_next      = S_LAST;
            end
            // last threshold in: wrap the counters
            S_LAST:
            begin
                if (tick_count_reg >= thr_rdata)
                begin
                    tick_count_next  = '0;
                    phase_index_next = '0;
                    if (!rep_reg)
                    begin
                        active_status_next = ST_OFF;
                    end
                end
                state_next = S_FIN;
            end
            // hand the result word over once the output is free
            S_FIN:
            begin
                if (!(res_valid_reg && res_stall))
                begin
                    res_valid_next          = 1'b1;
                    res_next.led_drive      = drive_bits_reg;
                    res_next.current_status = active_status_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            active_status_reg <= ST_OFF;
            tick_count_reg    <= '0;
            phase_index_reg   <= '0;
            drive_bits_reg    <= DRIVE_NONE;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            active_status_reg <= active_status_next;
            tick_count_reg    <= tick_count_next;
            phase_index_reg   <= phase_index_next;
            drive_bits_reg    <= drive_bits_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    // working copies and result word
    always_ff @(posedge clk)
    begin
        pat_reg   <= pat_next;
        pc_reg    <= pc_next;
        color_reg <= color_next;
        rep_reg   <= rep_next;
        res_reg   <= res_next;
    end

`ifndef NO_ASSERTIONS
    // phase index never points past the slot table
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_index_reg < SLOTS_PC)
        else $error("phase index beyond slot count");

    // active status always names a pattern entry
    assert property (@(posedge clk) disable iff (!rst_n)
        active_status_reg < PATTERNS)
        else $error("active status out of range");

    // a tick while off clears the drive
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd.action == ACT_TICK && active_status_reg == ST_OFF
        |=> drive_bits_reg == DRIVE_NONE)
        else $error("tick in off status left the drive on");

    // a finished result carries the state in effect
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && !(res_valid_reg && res_stall)
        |=> res_valid_reg && res_reg.current_status == active_status_reg)
        else $error("result word does not match status");
`endif

endmodule
